// ===== design/vob_pkg.sv =====
package vob_pkg;

    localparam int MAX_LEVELS = 7;
    localparam int GROUP      = 8;
    localparam int CNT_W      = 22;
    localparam int ATTR_W     = 34;
    localparam int LINK_W     = 44;
    localparam int NODE_W     = ATTR_W + LINK_W;
    localparam int RAM_DEPTH  = MAX_LEVELS * GROUP;
    localparam int RAM_AW     = 6;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 128;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PUSH = 8'b0000_0010,
        S_RD1  = 8'b0000_0100,
        S_CK1  = 8'b0000_1000,
        S_RD2  = 8'b0001_0000,
        S_CK2  = 8'b0010_0000,
        S_PAR  = 8'b0100_0000,
        S_ROOT = 8'b1000_0000
    } t_state;

    // one emitted node record
    typedef struct packed {
        logic             is_root;
        logic [CNT_W-1:0] voxel_total;
        logic [CNT_W-1:0] subtree_count;
        logic [CNT_W-1:0] child_start;
        logic [7:0]       child_mask;
        logic [7:0]       blue_out;
        logic [7:0]       green_out;
        logic [7:0]       red_out;
        logic             is_parent;
        logic             is_visible;
        logic [CNT_W-1:0] node_index;
    } t_rec;

endpackage

// ===== design/vob_ram.sv =====
module vob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/voxel_octree_builder.sv =====
// Builds a sparse voxel octree from voxels streamed in Morton order. Each
// voxel goes into the pending group of level 0; a full group of eight is
// scanned from the node memory once (a read and a check per entry) to
// test for a merge and, if the children differ, scanned again to emit
// every visible child, after which a parent (or merged leaf) is pushed one
// level up. A voxel that emits records hands its last record to the output
// register once back in idle; output stalls hold back each emission. The
// voxel input stays closed until that last record has moved out. After
// 8^levels_in_use voxels the root is emitted with is_root set and a new
// volume begins. Writing levels_in_use (0 acts as 1) also starts a new
// volume. The final record caused by a voxel carries tlast.
module voxel_octree_builder (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config: levels_in_use
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_data,
    // tdata: visible[0], red[8:1], green[16:9], blue[24:17]
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [vob_pkg::IN_W-1:0]  i_s_axis_tdata,
    // tdata: node_index, is_visible, is_parent, red_out, green_out, blue_out,
    // child_mask, child_start, subtree_count, voxel_total, is_root
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [vob_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                    o_m_axis_tlast
);
    import vob_pkg::*;

    t_state              r_state;
    logic [2:0]          r_lv;
    logic [2:0]          r_k;
    logic [2:0]          r_idx;
    logic [2:0]          r_fill [MAX_LEVELS];
    logic [CNT_W-1:0]    r_nodes;
    logic [CNT_W-1:0]    r_cov;
    logic [ATTR_W-1:0]   r_attr;
    logic [LINK_W-1:0]   r_links;
    logic [ATTR_W-1:0]   r_a0;
    logic                r_merge;
    logic [CNT_W-1:0]    r_cnt;
    logic [7:0]          r_mask;
    t_rec                r_hold;
    logic                r_hold_v;
    t_rec                r_out;
    logic                r_out_v;
    logic                r_out_last;

    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [RAM_AW-1:0]   ram_raddr;
    logic [NODE_W-1:0]   ram_rdata;
    logic [ATTR_W-1:0]   rd_attr;
    logic [LINK_W-1:0]   rd_links;
    logic [ATTR_W-1:0]   a0_ref;
    logic                out_free;
    logic                can_emit;
    logic                do_emit;
    logic [ATTR_W-1:0]   e_attr;
    logic [LINK_W-1:0]   e_links;
    logic                e_vis;
    logic                e_par;
    logic [CNT_W-1:0]    e_cov;
    t_rec                e_rec;
    logic                in_acc;
    logic                cfg_acc;
    logic                vis_in;
    logic [ATTR_W-1:0]   in_attr;

    // pending node memory, eight entries per level
    vob_ram #(.WIDTH(NODE_W), .DEPTH(RAM_DEPTH)) u_nodes (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata({r_links, r_attr}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign ram_we    = (r_state == S_PUSH) && (r_k < r_lv);
    assign ram_waddr = {r_k, r_fill[r_k]};
    assign ram_raddr = {r_k, r_idx};
    assign rd_attr   = ram_rdata[ATTR_W-1:0];
    assign rd_links  = ram_rdata[NODE_W-1:ATTR_W];
    assign a0_ref    = (r_idx == 3'd0) ? rd_attr : r_a0;

    // handshakes: idle with the last record handed over; config goes first
    assign o_cfg_ready     = (r_state == S_IDLE) && !r_hold_v;
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_hold_v && !i_cfg_valid;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc         = i_cfg_valid && o_cfg_ready;
    assign out_free        = !r_out_v || i_m_axis_tready;
    assign can_emit        = !r_hold_v || out_free;

    // incoming voxel as a leaf
    assign vis_in  = i_s_axis_tdata[0];
    assign in_attr = vis_in ? {8'd0, i_s_axis_tdata[24:1], 1'b0, 1'b1} : '0;

    // record builder
    assign e_attr  = (r_state == S_ROOT) ? r_attr : rd_attr;
    assign e_links = (r_state == S_ROOT) ? r_links : rd_links;
    assign e_vis   = e_attr[0];
    assign e_par   = e_attr[1];
    assign do_emit = can_emit && ((r_state == S_ROOT) ||
                                  ((r_state == S_CK2) && rd_attr[0]));
    assign e_cov   = (e_vis && !e_par)
                   ? r_cov + (CNT_W'(1) << (5'(r_k) * 5'd3)) : r_cov;

    always_comb begin
        e_rec               = '0;
        e_rec.node_index    = r_nodes;
        e_rec.is_visible    = e_vis;
        e_rec.is_parent     = e_par;
        e_rec.red_out       = e_par ? 8'd0 : e_attr[9:2];
        e_rec.green_out     = e_par ? 8'd0 : e_attr[17:10];
        e_rec.blue_out      = e_par ? 8'd0 : e_attr[25:18];
        e_rec.child_mask    = e_par ? e_attr[33:26] : 8'd0;
        e_rec.child_start   = e_par ? e_links[CNT_W-1:0] : '0;
        e_rec.subtree_count = e_links[LINK_W-1:CNT_W];
        e_rec.voxel_total   = e_cov;
        e_rec.is_root       = (r_state == S_ROOT);
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lv       <= 3'd7;
            r_k        <= '0;
            r_idx      <= '0;
            r_nodes    <= '0;
            r_cov      <= '0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            if (r_out_v && i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (do_emit) begin
                if (r_hold_v) begin
                    r_out      <= r_hold;
                    r_out_v    <= 1'b1;
                    r_out_last <= 1'b0;
                end
                r_hold   <= e_rec;
                r_hold_v <= 1'b1;
                r_nodes  <= r_nodes + CNT_W'(1);
                r_cov    <= e_cov;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_hold_v && out_free) begin
                        // flush the final record of the previous voxel
                        r_out      <= r_hold;
                        r_out_v    <= 1'b1;
                        r_out_last <= 1'b1;
                        r_hold_v   <= 1'b0;
                    end else if (cfg_acc) begin
                        r_lv    <= (i_cfg_data == 3'd0) ? 3'd1 : i_cfg_data;
                        r_nodes <= '0;
                        r_cov   <= '0;
                        for (int i = 0; i < MAX_LEVELS; i++) begin
                            r_fill[i] <= '0;
                        end
                    end else if (in_acc && !r_hold_v) begin
                        r_attr  <= in_attr;
                        r_links <= '0;
                        r_k     <= '0;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_k >= r_lv) begin
                        r_state <= S_ROOT;
                    end else if (r_fill[r_k] == 3'd7) begin
                        r_fill[r_k] <= '0;
                        r_idx       <= '0;
                        r_merge     <= 1'b1;
                        r_cnt       <= '0;
                        r_state     <= S_RD1;
                    end else begin
                        r_fill[r_k] <= r_fill[r_k] + 3'd1;
                        r_state     <= S_IDLE;
                    end
                end
                S_RD1: r_state <= S_CK1;
                S_CK1: begin
                    // merge test: no parent, same visibility and colour
                    logic m;
                    m = r_merge && !rd_attr[1] &&
                        (rd_attr[25:2] == a0_ref[25:2]) && (rd_attr[0] == a0_ref[0]);
                    if (r_idx == 3'd0) begin
                        r_a0 <= rd_attr;
                    end else begin
                        r_cnt <= r_cnt + rd_links[LINK_W-1:CNT_W] + CNT_W'(1);
                    end
                    r_merge <= m;
                    if (r_idx == 3'd7) begin
                        if (m) begin
                            r_attr  <= {8'd0, r_a0[25:2], 1'b0, r_a0[0]};
                            r_links <= {r_cnt + rd_links[LINK_W-1:CNT_W] + CNT_W'(1),
                                        CNT_W'(0)};
                            r_k     <= r_k + 3'd1;
                            r_state <= S_PUSH;
                        end else begin
                            r_idx   <= '0;
                            r_cnt   <= '0;
                            r_mask  <= '0;
                            r_state <= S_RD2;
                        end
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_RD1;
                    end
                end
                S_RD2: r_state <= S_CK2;
                S_CK2: begin
                    // emit each visible child
                    if (!rd_attr[0] || can_emit) begin
                        if (rd_attr[0]) begin
                            r_mask[r_idx] <= 1'b1;
                            r_cnt <= r_cnt + rd_links[LINK_W-1:CNT_W] + CNT_W'(1);
                        end
                        if (r_idx == 3'd7) begin
                            r_state <= S_PAR;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_RD2;
                        end
                    end
                end
                S_PAR: begin
                    r_attr  <= {r_mask, 24'd0, 1'b1, (r_mask != 8'd0)};
                    r_links <= {r_cnt, r_nodes - CNT_W'(1)};
                    r_k     <= r_k + 3'd1;
                    r_state <= S_PUSH;
                end
                S_ROOT: begin
                    if (can_emit) begin
                        r_nodes <= '0;
                        r_cov   <= '0;
                        for (int i = 0; i < MAX_LEVELS; i++) begin
                            r_fill[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {5'd0, r_out};
endmodule
